// ===== sv/pgsm_pkg.sv =====
`default_nettype none
package pgsm_pkg;

    localparam int SampleWidth = 16;
    localparam int ResultWidth = 32;
    localparam int MaxSlice    = 1024;
    localparam int PosWidth    = 10;
    localparam int SliceWidth  = 12;
    localparam int GroupWidth  = 13;
    localparam int LevelWidth  = 2;
    localparam int QueueDepth  = 4;
    localparam int QueuePtrW   = 2;
    localparam int DivSteps    = 32;
    localparam int DivCntW     = 5;
    localparam int CfgIdxW     = 3;
    localparam int CfgDataW    = 13;
    localparam int OutDataW    = 48;

    typedef enum logic [CfgIdxW-1:0] {
        REG_MEAN_MODE    = 3'd0,
        REG_SLICE_LENGTH = 3'd1,
        REG_LEVEL_COUNT  = 3'd2,
        REG_LEVEL_SIZE_A = 3'd3,
        REG_LEVEL_SIZE_B = 3'd4,
        REG_LEVEL_SIZE_C = 3'd5,
        REG_LEVEL_SIZE_D = 3'd6,
        REG_AXIS_LENGTH  = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic              mean_mode;
        logic [10:0]       slice_length;
        logic [2:0]        level_count;
        logic [3:0][5:0]   lvl_dim;
        logic [12:0]       axis_length;
    } cfg_t;

    typedef struct packed {
        logic [SampleWidth-1:0] sample;
        logic [PosWidth-1:0]    pos;
        logic                   first;
        logic                   last_slice;
        logic [LevelWidth-1:0]  lev;
        logic                   row_end;
        logic                   mean;
        logic [GroupWidth-1:0]  group;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_ACC,
        BK_DIV,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic pop;
        logic acc_we;
        logic div_step;
        logic out_load;
    } back_ctl_t;

endpackage
`default_nettype wire

// ===== sv/pyramid_group_sum_mean_reduce.sv =====
// Grouped sum / mean reduction over a stream of signed Q8.8 samples.
// Input: s_tvalid/s_tready/s_tdata, one sample per transfer. Samples come as
// rows of slices; each level of a row groups size*size slices (axis_length
// slices in global mode), and each position is summed over its group.
// Output: m_tvalid/m_tready/m_tdata/m_tlast, one transfer per sample that
// closes its group; m_tlast marks the last result of a row.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; write
// only while the block is idle.
// The front counts positions and slices and queues up to four commands; the
// back does a read-modify-write of the accumulator memory, then a 32-step
// radix-2 divider in mean mode. The back takes one command at a time through
// idle, read and accumulate states, then divide (mean mode only) and output
// states when the sample closes a group; the divider sets the worst case.
// Reset clears counters, queue and output, sets mean_mode to 0 and the other
// registers to 1; accumulators need no clearing. While m_tready is low the
// result register holds, the back stalls, the queue fills and s_tready drops.
`default_nettype none
module pyramid_group_sum_mean_reduce (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [pgsm_pkg::SampleWidth-1:0]  s_tdata,   // [15:0] sample
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [pgsm_pkg::OutDataW-1:0]          m_tdata,   // [31:0] reduced_value,
                                                              // [33:32] level_index,
                                                              // [43:34] position
    output logic                                   m_tlast,   // row_end
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pgsm_pkg::CfgIdxW-1:0]      cfg_index,
    input  wire logic [pgsm_pkg::CfgDataW-1:0]     cfg_data
);

    pgsm_pkg::cfg_t cfg_reg;
    pgsm_pkg::cmd_t push_cmd;
    pgsm_pkg::cmd_t head_cmd;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mean_mode    <= 1'b0;
            cfg_reg.slice_length <= 11'd1;
            cfg_reg.level_count  <= 3'd1;
            cfg_reg.lvl_dim      <= {4{6'd1}};
            cfg_reg.axis_length  <= 13'd1;
        end
        else if (cfg_valid)
        begin
            unique case (pgsm_pkg::reg_index_t'(cfg_index))
                pgsm_pkg::REG_MEAN_MODE:    cfg_reg.mean_mode    <= cfg_data[0];
                pgsm_pkg::REG_SLICE_LENGTH: cfg_reg.slice_length <= cfg_data[10:0];
                pgsm_pkg::REG_LEVEL_COUNT:  cfg_reg.level_count  <= cfg_data[2:0];
                pgsm_pkg::REG_LEVEL_SIZE_A: cfg_reg.lvl_dim[0]   <= cfg_data[5:0];
                pgsm_pkg::REG_LEVEL_SIZE_B: cfg_reg.lvl_dim[1]   <= cfg_data[5:0];
                pgsm_pkg::REG_LEVEL_SIZE_C: cfg_reg.lvl_dim[2]   <= cfg_data[5:0];
                pgsm_pkg::REG_LEVEL_SIZE_D: cfg_reg.lvl_dim[3]   <= cfg_data[5:0];
                pgsm_pkg::REG_AXIS_LENGTH:  cfg_reg.axis_length  <= cfg_data;
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    pgsm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  (s_tdata),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    pgsm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty)
    );

    pgsm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata),
        .out_last    (m_tlast)
    );

endmodule
`default_nettype wire

// ===== sv/pgsm_front.sv =====
`default_nettype none
module pgsm_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pgsm_pkg::cfg_t                    cfg,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [pgsm_pkg::SampleWidth-1:0]  in_sample,
    output logic                                   push,
    output pgsm_pkg::cmd_t                         push_cmd,
    input  wire logic                              queue_full
);

    logic [pgsm_pkg::PosWidth-1:0]   pos_cnt_reg, pos_cnt_next;
    logic [pgsm_pkg::SliceWidth-1:0] slc_cnt_reg, slc_cnt_next;
    logic [pgsm_pkg::LevelWidth-1:0] lev_cnt_reg, lev_cnt_next;

    logic [10:0]                     len;
    logic [2:0]                      nlev;
    logic [pgsm_pkg::LevelWidth-1:0] lev;
    logic [5:0]                      size_a;
    logic [5:0]                      size_l;
    logic [5:0]                      size_raw;
    logic                            global_mode;
    logic [11:0]                     size_sq;
    logic [pgsm_pkg::GroupWidth-1:0] axis;
    logic [pgsm_pkg::GroupWidth-1:0] group;
    logic [pgsm_pkg::PosWidth-1:0]   pos;
    logic [pgsm_pkg::SliceWidth-1:0] slc;
    logic                            last_slice;
    logic                            last_pos;
    logic                            last_lev;
    logic                            accept;

    always_comb
    begin
        if (cfg.slice_length == 11'd0)
            len = 11'd1;
        else if (cfg.slice_length > 11'(pgsm_pkg::MaxSlice))
            len = 11'(pgsm_pkg::MaxSlice);
        else
            len = cfg.slice_length;

        if (cfg.level_count == 3'd0)
            nlev = 3'd1;
        else if (cfg.level_count > 3'd4)
            nlev = 3'd4;
        else
            nlev = cfg.level_count;

        if ({1'b0, lev_cnt_reg} >= nlev)
            lev = pgsm_pkg::LevelWidth'(nlev - 3'd1);
        else
            lev = lev_cnt_reg;

        size_a      = (cfg.lvl_dim[0] == 6'd0) ? 6'd1 : cfg.lvl_dim[0];
        size_raw    = cfg.lvl_dim[lev];
        size_l      = (size_raw == 6'd0) ? 6'd1 : size_raw;
        size_sq     = {6'd0, size_l} * {6'd0, size_l};
        global_mode = (nlev == 3'd1) && (size_a == 6'd1);

        if (cfg.axis_length == 13'd0)
            axis = 13'd1;
        else if (cfg.axis_length > 13'd4096)
            axis = 13'd4096;
        else
            axis = cfg.axis_length;

        group = global_mode ? axis : {1'b0, size_sq};

        if ({1'b0, pos_cnt_reg} >= len)
            pos = pgsm_pkg::PosWidth'(len - 11'd1);
        else
            pos = pos_cnt_reg;

        if ({1'b0, slc_cnt_reg} >= group)
            slc = pgsm_pkg::SliceWidth'(group - 13'd1);
        else
            slc = slc_cnt_reg;

        last_slice = ({1'b0, slc} + 13'd1) >= group;
        last_pos   = ({1'b0, pos} + 11'd1) >= len;
        last_lev   = ({1'b0, lev} + 3'd1) >= nlev;
    end

    assign in_ready = !queue_full;
    assign accept   = in_valid && !queue_full;
    assign push     = accept;

    always_comb
    begin
        push_cmd.sample     = in_sample;
        push_cmd.pos        = pos;
        push_cmd.first      = (slc == '0);
        push_cmd.last_slice = last_slice;
        push_cmd.lev        = lev;
        push_cmd.row_end    = last_lev && last_pos;
        push_cmd.mean       = cfg.mean_mode;
        push_cmd.group      = group;
    end

    always_comb
    begin
        pos_cnt_next = pos_cnt_reg;
        slc_cnt_next = slc_cnt_reg;
        lev_cnt_next = lev_cnt_reg;
        if (accept)
        begin
            if (last_pos)
            begin
                pos_cnt_next = '0;
                if (last_slice)
                begin
                    slc_cnt_next = '0;
                    lev_cnt_next = last_lev ? '0 : lev + 2'd1;
                end
                else
                begin
                    slc_cnt_next = slc + 12'd1;
                    lev_cnt_next = lev;
                end
            end
            else
            begin
                pos_cnt_next = pos + 10'd1;
                slc_cnt_next = slc;
                lev_cnt_next = lev;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_cnt_reg <= '0;
            slc_cnt_reg <= '0;
            lev_cnt_reg <= '0;
        end
        else
        begin
            pos_cnt_reg <= pos_cnt_next;
            slc_cnt_reg <= slc_cnt_next;
            lev_cnt_reg <= lev_cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/pgsm_queue.sv =====
`default_nettype none
module pgsm_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire pgsm_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output pgsm_pkg::cmd_t      head_cmd,
    output logic                empty
);

    pgsm_pkg::cmd_t                   entry_reg [pgsm_pkg::QueueDepth];
    logic [pgsm_pkg::QueuePtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [pgsm_pkg::QueuePtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [pgsm_pkg::QueuePtrW:0]     count_reg, count_next;

    assign full     = (count_reg == (pgsm_pkg::QueuePtrW+1)'(pgsm_pkg::QueueDepth));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + pgsm_pkg::QueuePtrW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + pgsm_pkg::QueuePtrW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + (pgsm_pkg::QueuePtrW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (pgsm_pkg::QueuePtrW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/pgsm_back.sv =====
`default_nettype none
module pgsm_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              queue_empty,
    input  wire pgsm_pkg::cmd_t                    head_cmd,
    output logic                                   pop,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [pgsm_pkg::OutDataW-1:0]          out_data,
    output logic                                   out_last
);

    pgsm_pkg::back_state_t            state_reg, state_next;
    pgsm_pkg::back_ctl_t              ctl;

    logic [pgsm_pkg::ResultWidth-1:0] acc_mem [pgsm_pkg::MaxSlice];
    logic [pgsm_pkg::ResultWidth-1:0] rd_data_reg;

    pgsm_pkg::cmd_t                   cmd_reg;
    logic [pgsm_pkg::ResultWidth-1:0] res_reg;
    logic [pgsm_pkg::ResultWidth-1:0] quo_reg, quo_next;
    logic [pgsm_pkg::GroupWidth-1:0]  rem_reg, rem_next;
    logic                             neg_reg;
    logic [pgsm_pkg::DivCntW-1:0]     cnt_reg;
    logic                             out_valid_reg;
    logic [pgsm_pkg::ResultWidth-1:0] out_value_reg;
    logic [pgsm_pkg::LevelWidth-1:0]  out_lev_reg;
    logic [pgsm_pkg::PosWidth-1:0]    out_pos_reg;
    logic                             out_last_reg;

    logic [pgsm_pkg::ResultWidth-1:0] sample_ext;
    logic [pgsm_pkg::ResultWidth-1:0] sum;
    logic [pgsm_pkg::GroupWidth:0]    trial;
    logic                             fits;
    logic                             out_free;
    logic                             div_done;

    assign sample_ext = {{(pgsm_pkg::ResultWidth-pgsm_pkg::SampleWidth)
                          {cmd_reg.sample[pgsm_pkg::SampleWidth-1]}}, cmd_reg.sample};
    assign sum        = cmd_reg.first ? sample_ext : rd_data_reg + sample_ext;
    assign out_free   = !out_valid_reg || out_ready;
    assign div_done   = (cnt_reg == pgsm_pkg::DivCntW'(pgsm_pkg::DivSteps - 1));

    always_comb
    begin
        trial = {rem_reg, quo_reg[pgsm_pkg::ResultWidth-1]};
        fits  = trial >= {1'b0, cmd_reg.group};
        if (fits)
            rem_next = pgsm_pkg::GroupWidth'(trial - {1'b0, cmd_reg.group});
        else
            rem_next = trial[pgsm_pkg::GroupWidth-1:0];
        quo_next = {quo_reg[pgsm_pkg::ResultWidth-2:0], fits};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pgsm_pkg::BK_IDLE:
                if (!queue_empty)
                    state_next = pgsm_pkg::BK_READ;
            pgsm_pkg::BK_READ:
                state_next = pgsm_pkg::BK_ACC;
            pgsm_pkg::BK_ACC:
                if (!cmd_reg.last_slice)
                    state_next = pgsm_pkg::BK_IDLE;
                else if (cmd_reg.mean)
                    state_next = pgsm_pkg::BK_DIV;
                else
                    state_next = pgsm_pkg::BK_OUT;
            pgsm_pkg::BK_DIV:
                if (div_done)
                    state_next = pgsm_pkg::BK_OUT;
            pgsm_pkg::BK_OUT:
                if (out_free)
                    state_next = pgsm_pkg::BK_IDLE;
            default:
                state_next = pgsm_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            pgsm_pkg::BK_IDLE: ctl.pop      = !queue_empty;
            pgsm_pkg::BK_READ: ctl          = '0;
            pgsm_pkg::BK_ACC:  ctl.acc_we   = 1'b1;
            pgsm_pkg::BK_DIV:  ctl.div_step = 1'b1;
            pgsm_pkg::BK_OUT:  ctl.out_load = out_free;
            default:           ctl          = '0;
        endcase
    end

    assign pop = ctl.pop;

    always_ff @(posedge clk)
    begin
        if (ctl.acc_we)
            acc_mem[cmd_reg.pos] <= sum;
        rd_data_reg <= acc_mem[cmd_reg.pos];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pop)
            cmd_reg <= head_cmd;
        if (ctl.acc_we)
        begin
            res_reg <= sum;
            neg_reg <= sum[pgsm_pkg::ResultWidth-1];
            quo_reg <= sum[pgsm_pkg::ResultWidth-1] ? -sum : sum;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (ctl.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + pgsm_pkg::DivCntW'(1);
            if (div_done)
                res_reg <= neg_reg ? -quo_next : quo_next;
        end
        if (ctl.out_load)
        begin
            out_value_reg <= res_reg;
            out_lev_reg   <= cmd_reg.lev;
            out_pos_reg   <= cmd_reg.pos;
            out_last_reg  <= cmd_reg.row_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pgsm_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_data  = {4'd0, out_pos_reg, out_lev_reg, out_value_reg};

endmodule
`default_nettype wire
